// File: rtl/gcp_pkg.sv
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared types and constants of the grain crossfade player: field widths,
// operation and register codes, sequencer states and the mixer command bus.
// ----------------------------------------------------------------------------
package gcp_pkg;

   localparam int MAX_FRAME     = 8192;
   localparam int SAMPLE_BITS   = 24;
   localparam int INDEX_BITS    = $clog2(MAX_FRAME);
   localparam int FRAME_BITS    = 14;
   localparam int FADE_BITS     = 13;
   localparam int BANK_BITS     = 2;
   localparam int MEM_DEPTH     = 3 * MAX_FRAME;
   localparam int MEM_ADDR_BITS = $clog2(MEM_DEPTH);
   localparam int MEM_DATA_BITS = 2 * SAMPLE_BITS;
   // product sum of one channel: sample times a fade-length weight, plus sign
   localparam int ACC_BITS      = SAMPLE_BITS + FADE_BITS + 1;
   localparam int MAG_BITS      = ACC_BITS - 1;
   localparam int STEP_BITS     = $clog2(MAG_BITS + 1);

   localparam int REQ_DATA_BITS = ((INDEX_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int CSR_DATA_BITS = FRAME_BITS;

   localparam logic [FRAME_BITS-1:0] FRAME_LENGTH_RESET = FRAME_BITS'(1024);
   localparam logic [FADE_BITS-1:0]  FADE_LENGTH_RESET  = FADE_BITS'(256);
   localparam logic [FRAME_BITS-1:0] FRAME_LIMIT        = FRAME_BITS'(MAX_FRAME);

   localparam logic [BANK_BITS-1:0] BANK_STAGE_RESET = BANK_BITS'(0);
   localparam logic [BANK_BITS-1:0] BANK_NEXT_RESET  = BANK_BITS'(1);
   localparam logic [BANK_BITS-1:0] BANK_CUR_RESET   = BANK_BITS'(2);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_COMMIT = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef enum logic {
      CSR_FRAME_LENGTH = 1'b0,
      CSR_FADE_LENGTH  = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_RD_NXT,
      ST_CAP,
      ST_MIX_L,
      ST_WAIT_L,
      ST_MIX_R,
      ST_WAIT_R,
      ST_DONE
   } player_state_type;

   typedef enum logic [2:0] {
      MIX_IDLE,
      MIX_MUL_CUR,
      MIX_MUL_NXT,
      MIX_SUM,
      MIX_ABS,
      MIX_DIV,
      MIX_DONE
   } mix_state_type;

   typedef struct packed {
      logic                          start;
      logic signed [SAMPLE_BITS-1:0] cur_sample;
      logic signed [SAMPLE_BITS-1:0] nxt_sample;
      logic [FADE_BITS-1:0]          cur_weight;
      logic [FADE_BITS-1:0]          nxt_weight;
      logic [FADE_BITS-1:0]          divisor;
   } mix_cmd_type;

   typedef struct packed {
      logic                          done;
      logic signed [SAMPLE_BITS-1:0] value;
   } mix_rsp_type;

endpackage

// File: rtl/gcp_grain_mem.sv
// ----------------------------------------------------------------------------
// gcp_grain_mem
// Three grain banks in one array, one write port and one registered read port.
// Address is {bank, sample index}.
// ----------------------------------------------------------------------------
module gcp_grain_mem (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [gcp_pkg::MEM_ADDR_BITS-1:0] wr_addr,
   input  logic [gcp_pkg::MEM_DATA_BITS-1:0] wr_data,
   input  logic                              rd_en,
   input  logic [gcp_pkg::MEM_ADDR_BITS-1:0] rd_addr,
   output logic [gcp_pkg::MEM_DATA_BITS-1:0] rd_data
);

   logic [gcp_pkg::MEM_DATA_BITS-1:0] mem_ff [gcp_pkg::MEM_DEPTH];
   logic [gcp_pkg::MEM_DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/gcp_mix_unit.sv
// ----------------------------------------------------------------------------
// gcp_mix_unit
// One channel of the crossfade: (cur*wc + nxt*wn) / divisor, truncated toward
// zero. One multiplier used twice, then a restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module gcp_mix_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  gcp_pkg::mix_cmd_type cmd,
   output gcp_pkg::mix_rsp_type rsp
);

   gcp_pkg::mix_state_type state_ff, state_in;

   logic signed [gcp_pkg::SAMPLE_BITS-1:0] cur_ff, nxt_ff;
   logic [gcp_pkg::FADE_BITS-1:0]          wc_ff, wn_ff, div_ff;
   logic signed [gcp_pkg::ACC_BITS-1:0]    prod_ff, acc_ff;
   logic [gcp_pkg::MAG_BITS-1:0]           mag_ff;
   logic [gcp_pkg::FADE_BITS-1:0]          rem_ff;
   logic                                   neg_ff;
   logic [gcp_pkg::STEP_BITS-1:0]          step_ff;

   logic signed [gcp_pkg::SAMPLE_BITS-1:0] mul_sample;
   logic [gcp_pkg::FADE_BITS-1:0]          mul_weight;
   logic signed [gcp_pkg::ACC_BITS-1:0]    product;
   logic [gcp_pkg::FADE_BITS:0]            trial;
   logic                                   trial_ge;
   logic [gcp_pkg::FADE_BITS:0]            trial_sub;
   logic [gcp_pkg::SAMPLE_BITS-1:0]        quo;
   logic                                   last_step;

   // shared multiplier
   assign mul_sample = (state_ff == gcp_pkg::MIX_MUL_CUR) ? cur_ff : nxt_ff;
   assign mul_weight = (state_ff == gcp_pkg::MIX_MUL_CUR) ? wc_ff : wn_ff;
   assign product    = gcp_pkg::ACC_BITS'(mul_sample)
                     * gcp_pkg::ACC_BITS'($signed({1'b0, mul_weight}));

   // restoring divide step: dividend bits shift out of mag_ff, quotient in
   assign trial     = {rem_ff, mag_ff[gcp_pkg::MAG_BITS-1]};
   assign trial_ge  = (trial >= {1'b0, div_ff});
   assign trial_sub = trial - {1'b0, div_ff};
   assign quo       = mag_ff[gcp_pkg::SAMPLE_BITS-1:0];
   assign last_step = (step_ff == gcp_pkg::STEP_BITS'(gcp_pkg::MAG_BITS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gcp_pkg::MIX_IDLE: begin
            if (cmd.start) begin
               state_in = gcp_pkg::MIX_MUL_CUR;
            end
         end
         gcp_pkg::MIX_MUL_CUR: state_in = gcp_pkg::MIX_MUL_NXT;
         gcp_pkg::MIX_MUL_NXT: state_in = gcp_pkg::MIX_SUM;
         gcp_pkg::MIX_SUM:     state_in = gcp_pkg::MIX_ABS;
         gcp_pkg::MIX_ABS:     state_in = gcp_pkg::MIX_DIV;
         gcp_pkg::MIX_DIV: begin
            if (last_step) begin
               state_in = gcp_pkg::MIX_DONE;
            end
         end
         gcp_pkg::MIX_DONE:    state_in = gcp_pkg::MIX_IDLE;
         default:              state_in = gcp_pkg::MIX_IDLE;
      endcase
   end

   always_comb begin
      rsp.done  = 1'b0;
      rsp.value = '0;
      unique case (state_ff)
         gcp_pkg::MIX_DONE: begin
            rsp.done  = 1'b1;
            rsp.value = neg_ff ? $signed(-quo) : $signed(quo);
         end
         default: begin
            rsp.done  = 1'b0;
            rsp.value = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcp_pkg::MIX_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         gcp_pkg::MIX_IDLE: begin
            if (cmd.start) begin
               cur_ff <= cmd.cur_sample;
               nxt_ff <= cmd.nxt_sample;
               wc_ff  <= cmd.cur_weight;
               wn_ff  <= cmd.nxt_weight;
               div_ff <= cmd.divisor;
            end
         end
         gcp_pkg::MIX_MUL_CUR: prod_ff <= product;
         gcp_pkg::MIX_MUL_NXT: begin
            acc_ff  <= prod_ff;
            prod_ff <= product;
         end
         gcp_pkg::MIX_SUM: acc_ff <= acc_ff + prod_ff;
         gcp_pkg::MIX_ABS: begin
            neg_ff  <= acc_ff[gcp_pkg::ACC_BITS-1];
            mag_ff  <= acc_ff[gcp_pkg::ACC_BITS-1]
                     ? gcp_pkg::MAG_BITS'(-acc_ff)
                     : gcp_pkg::MAG_BITS'(acc_ff);
            rem_ff  <= '0;
            step_ff <= '0;
         end
         gcp_pkg::MIX_DIV: begin
            rem_ff  <= trial_ge ? trial_sub[gcp_pkg::FADE_BITS-1:0]
                                : trial[gcp_pkg::FADE_BITS-1:0];
            mag_ff  <= {mag_ff[gcp_pkg::MAG_BITS-2:0], trial_ge};
            step_ff <= step_ff + 1'b1;
         end
         default: ;
      endcase
   end

endmodule

// File: rtl/grain_crossfade_player_top.sv
// ----------------------------------------------------------------------------
// grain_crossfade_player_top
// Stereo grain looper with a linear crossfade between current and next grain.
//
// req channel: one beat per command. tuser carries the operation (load,
// commit, tick); tdata carries sample index and the stereo sample for a load.
// Load and commit complete in the cycle they are taken. A tick reads the
// current and next bank entries (registered memory read) and, while a fade
// runs, mixes each channel in the shared mixer: two multiplies, a sum, a sign
// fix and a 37-step divider. A tick before the first commit skips the read
// and mix; req_tready is low until the beat is in the output register.
// rsp channel: one beat per tick, held in an output register. A stalled
// receiver holds the beat; loads and commits go on meanwhile, a further tick
// waits in its last state until the register frees.
// csr channel: always ready, writes frame_length (0) or fade_length (1).
// Reset clears roles, positions and flags; bank contents stay as they were
// and are only valid once loaded.
// ----------------------------------------------------------------------------
module grain_crossfade_player_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample_index, left_in, right_in, zero pad
   input  logic [gcp_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // operation
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // left_out, right_out
   output logic [gcp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // fading
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [gcp_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int SB = gcp_pkg::SAMPLE_BITS;
   localparam int IB = gcp_pkg::INDEX_BITS;

   gcp_pkg::player_state_type state_ff, state_in;

   logic [gcp_pkg::BANK_BITS-1:0]  stage_ff, next_ff, cur_ff;
   logic [gcp_pkg::BANK_BITS-1:0]  rd_cur_ff, rd_nxt_ff;
   logic [IB-1:0]                  play_pos_ff, rd_pos_ff;
   logic [gcp_pkg::FADE_BITS-1:0]  fade_pos_ff;
   logic                           fade_active_ff, loaded_ff;
   logic [gcp_pkg::FRAME_BITS-1:0] frame_len_ff;
   logic [gcp_pkg::FADE_BITS-1:0]  fade_len_ff;
   logic                           mix_ff;
   logic [gcp_pkg::FADE_BITS-1:0]  wc_ff, wn_ff, len_ff;
   logic [gcp_pkg::MEM_DATA_BITS-1:0] cur_data_ff, nxt_data_ff;
   logic [SB-1:0]                  left_res_ff, right_res_ff;
   logic                           fading_res_ff;
   logic                           rsp_valid_ff;
   logic [SB-1:0]                  rsp_left_ff, rsp_right_ff;
   logic                           rsp_fading_ff;

   logic                           req_take, rsp_load;
   gcp_pkg::op_type                op;
   logic [IB-1:0]                  req_index;
   logic [SB-1:0]                  req_left, req_right;

   logic                           zero_fade, fade_end;
   logic [gcp_pkg::FADE_BITS-1:0]  p_clamp;
   logic [gcp_pkg::FADE_BITS:0]    p_inc;
   logic [gcp_pkg::FRAME_BITS-1:0] span, pos_inc;
   logic [IB-1:0]                  play_next;

   logic                              mem_wr_en, mem_rd_en;
   logic [gcp_pkg::MEM_ADDR_BITS-1:0] mem_wr_addr, mem_rd_addr;
   logic [gcp_pkg::MEM_DATA_BITS-1:0] mem_rd_data;
   gcp_pkg::mix_cmd_type              mix_cmd;
   gcp_pkg::mix_rsp_type              mix_rsp;

   assign op        = gcp_pkg::op_type'(req_tuser);
   assign req_index = req_tdata[IB-1:0];
   assign req_left  = req_tdata[IB+SB-1:IB];
   assign req_right = req_tdata[IB+2*SB-1:IB+SB];

   assign req_tready = (state_ff == gcp_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // tick bookkeeping
   assign zero_fade = fade_active_ff && (fade_len_ff == '0);
   assign p_clamp   = (fade_pos_ff > fade_len_ff) ? fade_len_ff : fade_pos_ff;
   assign p_inc     = {1'b0, p_clamp} + 1'b1;
   assign fade_end  = (p_inc >= {1'b0, fade_len_ff});
   assign span      = (frame_len_ff > gcp_pkg::FRAME_LIMIT) ? gcp_pkg::FRAME_LIMIT
                                                            : frame_len_ff;
   assign pos_inc   = gcp_pkg::FRAME_BITS'(play_pos_ff) + 1'b1;
   assign play_next = (pos_inc >= span) ? '0 : pos_inc[IB-1:0];

   assign mem_wr_en   = req_take && (op == gcp_pkg::OP_LOAD);
   assign mem_wr_addr = {stage_ff, req_index};

   gcp_grain_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data ({req_right, req_left}),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   gcp_mix_unit u_mix (
      .clock (clock),
      .reset (reset),
      .cmd   (mix_cmd),
      .rsp   (mix_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gcp_pkg::ST_IDLE: begin
            if (req_take && (op == gcp_pkg::OP_TICK)) begin
               state_in = loaded_ff ? gcp_pkg::ST_RD_CUR : gcp_pkg::ST_DONE;
            end
         end
         gcp_pkg::ST_RD_CUR: state_in = gcp_pkg::ST_RD_NXT;
         gcp_pkg::ST_RD_NXT: state_in = gcp_pkg::ST_CAP;
         gcp_pkg::ST_CAP:    state_in = mix_ff ? gcp_pkg::ST_MIX_L : gcp_pkg::ST_DONE;
         gcp_pkg::ST_MIX_L:  state_in = gcp_pkg::ST_WAIT_L;
         gcp_pkg::ST_WAIT_L: begin
            if (mix_rsp.done) begin
               state_in = gcp_pkg::ST_MIX_R;
            end
         end
         gcp_pkg::ST_MIX_R:  state_in = gcp_pkg::ST_WAIT_R;
         gcp_pkg::ST_WAIT_R: begin
            if (mix_rsp.done) begin
               state_in = gcp_pkg::ST_DONE;
            end
         end
         gcp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = gcp_pkg::ST_IDLE;
            end
         end
         default: state_in = gcp_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mem_rd_en          = 1'b0;
      mem_rd_addr        = {rd_cur_ff, rd_pos_ff};
      rsp_load           = 1'b0;
      mix_cmd.start      = 1'b0;
      mix_cmd.cur_sample = cur_data_ff[SB-1:0];
      mix_cmd.nxt_sample = nxt_data_ff[SB-1:0];
      mix_cmd.cur_weight = wc_ff;
      mix_cmd.nxt_weight = wn_ff;
      mix_cmd.divisor    = len_ff;
      unique case (state_ff)
         gcp_pkg::ST_RD_CUR: mem_rd_en = 1'b1;
         gcp_pkg::ST_RD_NXT: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = {rd_nxt_ff, rd_pos_ff};
         end
         gcp_pkg::ST_MIX_L: mix_cmd.start = 1'b1;
         gcp_pkg::ST_MIX_R: begin
            mix_cmd.start      = 1'b1;
            mix_cmd.cur_sample = cur_data_ff[2*SB-1:SB];
            mix_cmd.nxt_sample = nxt_data_ff[2*SB-1:SB];
         end
         gcp_pkg::ST_DONE: rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gcp_pkg::ST_IDLE;
         stage_ff       <= gcp_pkg::BANK_STAGE_RESET;
         next_ff        <= gcp_pkg::BANK_NEXT_RESET;
         cur_ff         <= gcp_pkg::BANK_CUR_RESET;
         play_pos_ff    <= '0;
         fade_pos_ff    <= '0;
         fade_active_ff <= 1'b0;
         loaded_ff      <= 1'b0;
         frame_len_ff   <= gcp_pkg::FRAME_LENGTH_RESET;
         fade_len_ff    <= gcp_pkg::FADE_LENGTH_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (gcp_pkg::csr_index_type'(csr_index))
               gcp_pkg::CSR_FRAME_LENGTH: frame_len_ff <= csr_data;
               gcp_pkg::CSR_FADE_LENGTH:
                  fade_len_ff <= csr_data[gcp_pkg::FADE_BITS-1:0];
               default: ;
            endcase
         end
         if (req_take) begin
            case (op)
               gcp_pkg::OP_COMMIT: begin
                  if (!loaded_ff) begin
                     stage_ff    <= cur_ff;
                     cur_ff      <= stage_ff;
                     play_pos_ff <= '0;
                     loaded_ff   <= 1'b1;
                  end else begin
                     stage_ff       <= next_ff;
                     next_ff        <= stage_ff;
                     fade_pos_ff    <= '0;
                     fade_active_ff <= 1'b1;
                  end
               end
               gcp_pkg::OP_TICK: begin
                  if (loaded_ff) begin
                     play_pos_ff <= play_next;
                     if (zero_fade) begin
                        cur_ff         <= next_ff;
                        next_ff        <= cur_ff;
                        fade_active_ff <= 1'b0;
                     end else if (fade_active_ff) begin
                        if (fade_end) begin
                           cur_ff         <= next_ff;
                           next_ff        <= cur_ff;
                           fade_active_ff <= 1'b0;
                           fade_pos_ff    <= p_inc[gcp_pkg::FADE_BITS-1:0];
                        end else begin
                           fade_pos_ff <= fade_pos_ff + 1'b1;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // tick datapath
   always_ff @(posedge clock) begin
      if (req_take && (op == gcp_pkg::OP_TICK)) begin
         rd_pos_ff     <= play_pos_ff;
         fading_res_ff <= loaded_ff && fade_active_ff;
         rd_cur_ff     <= zero_fade ? next_ff : cur_ff;
         rd_nxt_ff     <= next_ff;
         mix_ff        <= fade_active_ff && !zero_fade;
         wc_ff         <= fade_len_ff - p_clamp;
         wn_ff         <= p_clamp;
         len_ff        <= fade_len_ff;
         left_res_ff   <= '0;
         right_res_ff  <= '0;
      end
      if (state_ff == gcp_pkg::ST_RD_NXT) begin
         cur_data_ff <= mem_rd_data;
      end
      if (state_ff == gcp_pkg::ST_CAP) begin
         nxt_data_ff <= mem_rd_data;
         if (!mix_ff) begin
            left_res_ff  <= cur_data_ff[SB-1:0];
            right_res_ff <= cur_data_ff[2*SB-1:SB];
         end
      end
      if ((state_ff == gcp_pkg::ST_WAIT_L) && mix_rsp.done) begin
         left_res_ff <= mix_rsp.value;
      end
      if ((state_ff == gcp_pkg::ST_WAIT_R) && mix_rsp.done) begin
         right_res_ff <= mix_rsp.value;
      end
      if (rsp_load) begin
         rsp_left_ff   <= left_res_ff;
         rsp_right_ff  <= right_res_ff;
         rsp_fading_ff <= fading_res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_right_ff, rsp_left_ff};
   assign rsp_tuser  = rsp_fading_ff;

endmodule
